### rtl/lbmc_pkg.sv
// shared types and constants for the led blink mode controller
// no dependencies; imported by lbmc_led_channel and the top level
`default_nettype none

package lbmc_pkg;

   // sizes
   localparam int LED_COUNT  = 14;
   localparam int OUT_W      = 14;
   localparam int IDX_W      = 4;
   localparam int MODE_W     = 3;
   localparam int COUNT_W    = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // item kinds carried in tuser
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_SET  = 1'b1;

   // led modes
   localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ON       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BLINK_2HZ = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BLINK_1HZ = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BLINK_HALF = 3'd4;
   localparam logic [MODE_W-1:0] FLASH_BASE    = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

   // per-beat control shared by all led channels
   typedef struct packed {
      logic              tick_en;
      logic [MODE_W-1:0] set_mode;
      logic              fast;
      logic              quarter;
      logic              half;
      logic              ph_fast;
      logic              ph_mid;
      logic              ph_slow;
   } lbmc_chan_ctrl_type;

endpackage

`default_nettype wire

### rtl/led_blink_mode_controller_top.sv
// led blink mode controller, top level: stream ports, phases, led channels
// depends on lbmc_pkg and lbmc_led_channel
// flow: an accepted beat is held in the input register and, once the output is
// free, is processed into the result register that drives rsp_tvalid; one beat per
// cycle sustained while rsp_tready holds, set by the single update of the per-led state registers.
// reset: synchronous, clears modes, countdowns, levels, phases and both stages
`default_nettype none

module led_blink_mode_controller_top
   import lbmc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [3:0] led_index, [6:4] mode, [7] tick_fast, [8] tick_quarter,
   // [9] tick_half, [15:10] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [13:0] led_levels, [27:14] led_changed, [31:28] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic              in_action_ff;
   logic [IDX_W-1:0]  in_idx_ff;
   logic [MODE_W-1:0] in_mode_ff;
   logic              in_fast_ff, in_quarter_ff, in_half_ff;

   // phases
   logic ph_fast_ff, ph_fast_in;
   logic ph_mid_ff, ph_mid_in;
   logic ph_slow_ff, ph_slow_in;

   // output stage
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_levels_ff, rsp_changed_ff;

   logic               accept, proc, out_ready, tick_go;
   lbmc_chan_ctrl_type ctrl;
   logic [LED_COUNT-1:0] lvl_q, lvl_d;
   logic [15:0]          lvl_q16, lvl_d16;

   // handshake
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;
   assign accept     = req_tvalid && req_tready;
   assign tick_go    = proc && (in_action_ff == ACTION_TICK);

   assign in_valid_in  = accept ? 1'b1 : (proc ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = proc ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_action_ff  <= req_tuser;
         in_idx_ff     <= req_tdata[3:0];
         in_mode_ff    <= req_tdata[6:4];
         in_fast_ff    <= req_tdata[7];
         in_quarter_ff <= req_tdata[8];
         in_half_ff    <= req_tdata[9];
      end
   end

   // blink phases; slow phase toggles when mid phase rises
   always_comb begin
      ph_fast_in = ph_fast_ff;
      ph_mid_in  = ph_mid_ff;
      ph_slow_in = ph_slow_ff;
      if (tick_go) begin
         ph_fast_in = ph_fast_ff ^ in_quarter_ff;
         ph_mid_in  = ph_mid_ff ^ in_half_ff;
         ph_slow_in = ph_slow_ff ^ (in_half_ff && ph_mid_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_fast_ff <= 1'b0;
         ph_mid_ff  <= 1'b0;
         ph_slow_ff <= 1'b0;
      end else begin
         ph_fast_ff <= ph_fast_in;
         ph_mid_ff  <= ph_mid_in;
         ph_slow_ff <= ph_slow_in;
      end
   end

   // shared channel control
   always_comb begin
      ctrl.tick_en  = tick_go;
      ctrl.set_mode = in_mode_ff;
      ctrl.fast     = in_fast_ff;
      ctrl.quarter  = in_quarter_ff;
      ctrl.half     = in_half_ff;
      ctrl.ph_fast  = ph_fast_in;
      ctrl.ph_mid   = ph_mid_in;
      ctrl.ph_slow  = ph_slow_in;
   end

   // led channels; an out-of-range index selects none
   for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
      lbmc_led_channel u_chan (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .wr_en   (proc && (in_action_ff == ACTION_SET) && (in_idx_ff == IDX_W'(i))),
         .level_q (lvl_q[i]),
         .level_d (lvl_d[i])
      );
   end

   assign lvl_q16 = 16'(lvl_q);
   assign lvl_d16 = 16'(lvl_d);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (proc) begin
         rsp_levels_ff  <= lvl_d16[OUT_W-1:0];
         rsp_changed_ff <= lvl_d16[OUT_W-1:0] ^ lvl_q16[OUT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-2*OUT_W)'(0), rsp_changed_ff, rsp_levels_ff};

   // a set-mode beat never changes a level
   a_set_no_change: assert property (@(posedge clock) disable iff (reset)
      proc && (in_action_ff == ACTION_SET) |=> rsp_changed_ff == '0)
      else $error("set-mode beat reported a level change");

   // a pending result always matches the live level state
   a_levels_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_levels_ff == lvl_q16[OUT_W-1:0])
      else $error("pending result out of step with level state");

   // input stalls only when both stages are full and blocked
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without back pressure");

   // a processed beat always yields a result next cycle
   a_proc_result: assert property (@(posedge clock) disable iff (reset)
      proc |=> rsp_valid_ff)
      else $error("processed beat lost its result");

endmodule

`default_nettype wire

### rtl/lbmc_led_channel.sv
// one led channel: mode, flash countdown and level register
// depends on lbmc_pkg
`default_nettype none

module lbmc_led_channel
   import lbmc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lbmc_chan_ctrl_type ctrl,
   input  wire logic               wr_en,
   output logic                    level_q,
   output logic                    level_d
);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               level_ff, level_in;
   logic [3:0]         flash_add;
   logic [COUNT_W:0]   sum;

   // twice the number of flashes requested
   assign flash_add = {mode_ff - FLASH_BASE, 1'b0};

   // next channel state
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      level_in = level_ff;
      sum      = '0;
      if (wr_en) begin
         mode_in = ctrl.set_mode;
      end else if (ctrl.tick_en) begin
         if (count_ff != '0) begin
            // flash still running: fold in a new request, then step
            if (mode_ff > FLASH_BASE) begin
               sum      = {1'b0, count_ff} + (COUNT_W+1)'(flash_add);
               count_in = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
               mode_in  = MODE_OFF;
            end
            if (ctrl.fast) begin
               count_in = count_in - COUNT_W'(1);
               level_in = ~level_ff;
            end
         end else begin
            case (mode_ff)
               MODE_OFF:        level_in = 1'b0;
               MODE_ON:         level_in = 1'b1;
               MODE_BLINK_2HZ:  if (ctrl.quarter) level_in = ctrl.ph_fast;
               MODE_BLINK_1HZ:  if (ctrl.half) level_in = ctrl.ph_mid;
               MODE_BLINK_HALF: if (ctrl.half) level_in = ctrl.ph_slow;
               default: begin
                  // flash request: load countdown, level held
                  count_in = COUNT_W'(flash_add);
                  mode_in  = MODE_OFF;
               end
            endcase
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OFF;
         count_ff <= '0;
         level_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

   assign level_q = level_ff;
   assign level_d = level_in;

endmodule

`default_nettype wire

### tb/sv/lbmc_checker.sv
// checker for the led blink mode controller: watches both stream channels,
// predicts every result beat and compares it field by field; uses lbmc_pkg
`timescale 1ns / 1ps

module lbmc_checker
   import lbmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // [3:0] led_index, [6:4] mode, [7] tick_fast, [8] tick_quarter, [9] tick_half
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [13:0] led_levels, [27:14] led_changed
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    results_checked
);

   localparam int MAX_REPORTS = 30;

   typedef struct packed {
      logic [OUT_W-1:0] changed;
      logic [OUT_W-1:0] levels;
   } led_result_type;

   // predicted controller state
   logic [MODE_W-1:0]  mode_mem [LED_COUNT];
   logic [COUNT_W-1:0] flash_cnt [LED_COUNT];
   logic [OUT_W-1:0]   lit;
   logic               ph_fast, ph_mid, ph_slow;

   led_result_type expected_leds [$];

   // advance the predicted state by one accepted beat
   task automatic predict_leds(input logic is_set, input logic [IDX_W-1:0] idx,
                               input logic [MODE_W-1:0] new_mode, input logic fast,
                               input logic quarter, input logic half,
                               output led_result_type res);
      logic [OUT_W-1:0] prior;
      logic [OUT_W-1:0] nxt;
      logic             val;
      logic [COUNT_W:0] sum;
      prior = lit;
      if (is_set == ACTION_SET) begin
         if (idx < LED_COUNT) mode_mem[idx] = new_mode;
      end else begin
         // phases move before any led looks at them
         if (quarter) ph_fast = ~ph_fast;
         if (half) begin
            ph_mid = ~ph_mid;
            if (ph_mid) ph_slow = ~ph_slow;
         end
         nxt = lit;
         for (int i = 0; i < LED_COUNT; i++) begin
            val = lit[i];
            if (flash_cnt[i] != '0) begin
               // running flash: pending request piles on, fast strobe toggles
               if (mode_mem[i] > FLASH_BASE) begin
                  sum = {1'b0, flash_cnt[i]}
                        + (COUNT_W+1)'({mode_mem[i] - FLASH_BASE, 1'b0});
                  flash_cnt[i] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
                  mode_mem[i] = MODE_OFF;
               end
               if (fast) begin
                  flash_cnt[i] = flash_cnt[i] - 1'b1;
                  val = ~val;
               end
            end else begin
               case (mode_mem[i])
                  MODE_OFF:        val = 1'b0;
                  MODE_ON:         val = 1'b1;
                  MODE_BLINK_2HZ:  if (quarter) val = ph_fast;
                  MODE_BLINK_1HZ:  if (half) val = ph_mid;
                  MODE_BLINK_HALF: if (half) val = ph_slow;
                  default: begin
                     // flash request loads the countdown, level held
                     flash_cnt[i] = COUNT_W'({mode_mem[i] - FLASH_BASE, 1'b0});
                     mode_mem[i] = MODE_OFF;
                  end
               endcase
            end
            nxt[i] = val;
         end
         lit = nxt;
      end
      res.levels  = lit;
      res.changed = lit ^ prior;
   endtask

   // pop on each result beat first, then queue the prediction for a new request beat
   always @(posedge clock) begin : monitor
      led_result_type got;
      led_result_type want;
      led_result_type fresh;
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            mode_mem[i]  = MODE_OFF;
            flash_cnt[i] = '0;
         end
         lit     = '0;
         ph_fast = 1'b0;
         ph_mid  = 1'b0;
         ph_slow = 1'b0;
         expected_leds.delete();
         fail_count      = 0;
         results_checked = 0;
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[2*OUT_W-1:0];
            if (expected_leds.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: unexpected result beat, actual %h", $time, rsp_tdata);
            end else begin
               want = expected_leds.pop_front();
               results_checked++;
               if (got.levels !== want.levels) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: led_levels expected %h actual %h",
                              $time, want.levels, got.levels);
               end
               if (got.changed !== want.changed) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: led_changed expected %h actual %h",
                              $time, want.changed, got.changed);
               end
               if (rsp_tdata[RSP_DATA_W-1:2*OUT_W] !== '0) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: pad bits expected 0 actual %h",
                              $time, rsp_tdata[RSP_DATA_W-1:2*OUT_W]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_leds(req_tuser, req_tdata[3:0], req_tdata[6:4], req_tdata[7],
                         req_tdata[8], req_tdata[9], fresh);
            expected_leds.push_back(fresh);
         end
         pending_count <= expected_leds.size();
      end
   end

endmodule

### tb/sv/tb_led_blink_mode_controller_top.sv
// testbench top for the led blink mode controller: clock, reset, request
// stimulus, result back-pressure and the verdict; uses lbmc_pkg and lbmc_checker
`timescale 1ns / 1ps

module tb_led_blink_mode_controller_top;
   import lbmc_pkg::*;

   localparam logic [MODE_W-1:0] MODE_FLASH_ONCE   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_FLASH_TWICE  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_FLASH_THRICE = 3'd7;
   localparam int RANDOM_ITEMS = 700;
   localparam int TAIL_CYCLES  = 12;

   typedef enum int {SC_PROGRAM, SC_BLINK, SC_PILEUP, SC_NOISE, SC_PAUSE, SC_FLASH_ALL}
      scenario_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_WALK} rx_style_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = ACTION_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count, pending_count, results_checked;
   int beats_sent   = 0;
   int useful_beats = 0;
   int set_beats    = 0;
   int tick_beats   = 0;
   int burst_left   = 8;

   led_blink_mode_controller_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lbmc_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result back-pressure; the style is redrawn each time its random countdown runs out
   rx_style_type rx_style = RX_OPEN;
   int           rx_left  = 0;
   logic [7:0]   rx_walk  = 8'b1011_0010;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_left    <= 0;
      end else begin
         if (rx_left == 0) begin
            rx_style <= rx_style_type'($urandom_range(0, 3));
            rx_left  <= $urandom_range(20, 200);
         end else begin
            rx_left <= rx_left - 1;
         end
         rx_walk <= {rx_walk[6:0], rx_walk[7]};
         case (rx_style)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= rx_walk[0];
         endcase
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_req(input logic [IDX_W-1:0] idx,
                                                      input logic [MODE_W-1:0] m,
                                                      input logic fast, input logic quarter,
                                                      input logic half);
      return {6'b0, half, quarter, fast, m, idx};
   endfunction

   // one request beat, with burst and gap bookkeeping on the sender side
   task automatic send_beat(input logic user, input logic [REQ_DATA_W-1:0] data);
      int gap;
      req_tuser  <= user;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if (user == ACTION_SET) set_beats++;
      else tick_beats++;
      if (user == ACTION_TICK || data[3:0] < LED_COUNT) useful_beats++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // set-mode beat; strobe bits carry junk that must be ignored
   task automatic send_set(input logic [IDX_W-1:0] idx, input logic [MODE_W-1:0] m);
      send_beat(ACTION_SET, pack_req(idx, m, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
   endtask

   // tick beat; index and mode carry junk that must be ignored
   task automatic send_tick(input logic fast, input logic quarter, input logic half);
      send_beat(ACTION_TICK, pack_req(IDX_W'($urandom_range(0, 15)),
                                      MODE_W'($urandom_range(0, 7)), fast, quarter, half));
   endtask

   // hold the request side until every predicted result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [IDX_W-1:0] pick_led();
      return ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(LED_COUNT, 15))
                                         : IDX_W'($urandom_range(0, LED_COUNT - 1));
   endfunction

   function automatic scenario_type pick_scenario();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 8) return SC_PROGRAM;
      if (roll < 12) return SC_BLINK;
      if (roll < 14) return SC_PILEUP;
      if (roll < 16) return SC_NOISE;
      if (roll < 17) return SC_PAUSE;
      return SC_FLASH_ALL;
   endfunction

   // tick with strobe odds in percent
   task automatic random_tick(input int pf, input int pq, input int ph);
      send_tick($urandom_range(0, 99) < pf, $urandom_range(0, 99) < pq,
                $urandom_range(0, 99) < ph);
   endtask

   initial begin : stimulus
      scenario_type     scen;
      int               reps;
      logic [IDX_W-1:0] led;
      logic [9:0]       junk;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle tick, index extremes, ignored indexes, every mode
      send_tick(1'b0, 1'b0, 1'b0);
      send_set(4'd0, MODE_ON);
      send_set(4'd13, MODE_ON);
      send_tick(1'b0, 1'b0, 1'b0);
      send_set(4'd14, MODE_FLASH_THRICE);
      send_set(4'd15, MODE_ON);
      send_set(4'd1, MODE_BLINK_2HZ);
      send_set(4'd2, MODE_BLINK_1HZ);
      send_set(4'd3, MODE_BLINK_HALF);
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1);
      send_set(4'd4, MODE_FLASH_ONCE);
      send_set(4'd5, MODE_FLASH_TWICE);
      send_set(4'd6, MODE_FLASH_THRICE);
      send_tick(1'b0, 1'b0, 1'b1);
      // flash request while a countdown is running piles on
      send_set(4'd6, MODE_FLASH_THRICE);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b1, 1'b1, 1'b0);
      send_tick(1'b1, 1'b0, 1'b1);
      send_set(4'd0, MODE_OFF);
      send_set(4'd13, MODE_BLINK_2HZ);
      send_tick(1'b1, 1'b1, 1'b1);
      drain();

      // random part: mostly programmed sequences, some noise
      useful_beats = 0;
      while (useful_beats < RANDOM_ITEMS) begin
         scen = pick_scenario();
         case (scen)
            SC_PROGRAM: begin
               reps = $urandom_range(1, 5);
               repeat (reps) send_set(pick_led(), MODE_W'($urandom_range(0, 7)));
               reps = $urandom_range(3, 20);
               repeat (reps) random_tick(60, 30, 20);
            end
            SC_BLINK: begin
               reps = $urandom_range(10, 30);
               repeat (reps) random_tick(50, 40, 30);
            end
            SC_PILEUP: begin
               // repeated flash requests with no fast strobe drive the count toward its cap
               led = IDX_W'($urandom_range(0, LED_COUNT - 1));
               reps = $urandom_range(20, 50);
               repeat (reps) begin
                  send_set(led, MODE_W'($urandom_range(MODE_FLASH_ONCE, MODE_FLASH_THRICE)));
                  random_tick(0, 30, 30);
               end
               reps = $urandom_range(5, 40);
               repeat (reps) random_tick(90, 20, 20);
            end
            SC_NOISE: begin
               reps = $urandom_range(3, 15);
               repeat (reps) begin
                  junk = 10'($urandom);
                  send_beat(1'($urandom_range(0, 1)), {6'b0, junk});
               end
            end
            SC_PAUSE: drain();
            default: begin
               for (int i = 0; i < LED_COUNT; i++)
                  send_set(IDX_W'(i),
                           MODE_W'($urandom_range(MODE_FLASH_ONCE, MODE_FLASH_THRICE)));
               reps = $urandom_range(4, 20);
               repeat (reps) random_tick(70, 20, 20);
            end
         endcase
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d beats (%0d set-mode, %0d tick), %0d results checked",
               beats_sent, set_beats, tick_beats, results_checked);
      $display("modes off/on/blink/flash, ignored indexes, flash pileup to cap, stalls");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400_000;
      $display("timeout with %0d results outstanding", pending_count);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
rtl/lbmc_pkg.sv
rtl/lbmc_led_channel.sv
rtl/led_blink_mode_controller_top.sv
tb/sv/lbmc_checker.sv
tb/sv/tb_led_blink_mode_controller_top.sv
